// ===== rtl/cidr_text_normalizer_macros.svh =====
// ----------------------------------------------------------------------------
// cidr_text_normalizer_macros.svh
// Assertion macros shared by the checker files of the prefix normalizer.
// ----------------------------------------------------------------------------
`ifndef CIDR_TEXT_NORMALIZER_MACROS_SVH
`define CIDR_TEXT_NORMALIZER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CIDR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cidr_text_normalizer check failed");

// Check that a condition leads to a consequence in the following cycle.
`define CIDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cidr_text_normalizer check failed");

`endif

// ===== rtl/cidr_pkg.sv =====
// ----------------------------------------------------------------------------
// cidr_pkg
// Character codes, limits and the result record of the prefix normalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cidr_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [5:0] MAX_PREFIX  = 6'd32;
    localparam logic [5:0] PREFIX_OVER = 6'd33;

    typedef struct packed {
        logic [31:0] network;
        logic [5:0]  prefix_len;
        logic        clamped;
    } result_t;

endpackage

// ===== rtl/cidr_text_normalizer.sv =====
// ----------------------------------------------------------------------------
// cidr_text_normalizer
// IPv4 prefix text parser: one character in per beat, one masked prefix out
// per nonempty line.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, ch) carries one ASCII character a beat.
// Digits, '.' and '/' build the address and prefix; 0x0A closes the line and,
// if the line held any digit, '.' or '/', yields one result beat on the output
// channel (out_valid/out_ready, network, prefix_len, clamped). Other bytes are
// dropped.
// Throughput: one character per cycle while no result newline waits for the
// result slot, limited by the single update of the line accumulators in cidr_line_parse.
// After its newline is accepted, a result takes this path: the newline lands in
// the input register, and the result register loads as the newline leaves it for
// the parser, once the result slot is free.
// Reset clears the line state and both stages; nothing is pending after it.
// When the receiver stalls, the result register holds its beat; characters
// that produce no result keep flowing, and a newline that produces a result
// waits in the input register until the result slot frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cidr_text_normalizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] network,
    output logic [5:0]  prefix_len,
    output logic        clamped
);

    logic              hold_valid;
    logic [7:0]        hold_ch;
    logic              emit;
    logic              out_free;
    logic              advance;
    cidr_pkg::result_t res;

    // Move the held character on unless it needs a busy result slot
    assign advance = hold_valid && (!emit || out_free);

    cidr_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_ch    (hold_ch)
    );

    cidr_line_parse u_parse
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .ch    (hold_ch),
        .emit  (emit),
        .res   (res)
    );

    cidr_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && emit),
        .res        (res),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .network    (network),
        .prefix_len (prefix_len),
        .clamped    (clamped)
    );

endmodule

// ===== rtl/cidr_in_stage.sv =====
// ----------------------------------------------------------------------------
// cidr_in_stage
// Input register: holds one accepted character until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cidr_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       advance,
    output logic       hold_valid,
    output logic [7:0] hold_ch
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;

    // Take a new beat when empty or when the held one moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload of an accepted beat
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg <= ch;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_ch    = ch_reg;

endmodule

// ===== rtl/cidr_line_parse.sv =====
// ----------------------------------------------------------------------------
// cidr_line_parse
// Line accumulators: octets, dot count and prefix digits, plus the masked
// result that a newline produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cidr_line_parse
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       ch,
    output logic             emit,
    output cidr_pkg::result_t res
);

    logic [3:0][7:0] octet_reg,     octet_next;
    logic [1:0]      idx_reg,       idx_next;
    logic [2:0]      dots_reg,      dots_next;
    logic            in_pfx_reg,    in_pfx_next;
    logic [5:0]      pfx_reg,       pfx_next;
    logic            pfx_given_reg, pfx_given_next;
    logic            nonempty_reg,  nonempty_next;

    logic       is_digit;
    logic       is_newline;
    logic [3:0] digit;
    logic [1:0] sel;
    logic [7:0] cur;
    logic [7:0] octet_sum;
    logic [8:0] pfx_sum;
    logic [5:0] len;
    logic       flag;
    logic [31:0] mask;

    assign is_digit   = ch inside {[cidr_pkg::CH_ZERO:cidr_pkg::CH_NINE]};
    assign is_newline = (ch == cidr_pkg::CH_NEWLINE);
    assign digit      = 4'(ch - cidr_pkg::CH_ZERO);

    // First octet sits in the top byte
    assign sel       = ~idx_reg;
    assign cur       = octet_reg[sel];
    assign octet_sum = {cur[4:0], 3'b000} + {cur[6:0], 1'b0} + {4'b0000, digit};
    assign pfx_sum   = {pfx_reg, 3'b000} + {2'b00, pfx_reg, 1'b0} + {5'b00000, digit};

    // Advance the line state for one character
    always_comb
    begin
        octet_next     = octet_reg;
        idx_next       = idx_reg;
        dots_next      = dots_reg;
        in_pfx_next    = in_pfx_reg;
        pfx_next       = pfx_reg;
        pfx_given_next = pfx_given_reg;
        nonempty_next  = nonempty_reg;
        if (is_newline)
        begin
            octet_next     = '0;
            idx_next       = 2'd0;
            dots_next      = 3'd0;
            in_pfx_next    = 1'b0;
            pfx_next       = 6'd0;
            pfx_given_next = 1'b0;
            nonempty_next  = 1'b0;
        end
        else if (is_digit)
        begin
            nonempty_next = 1'b1;
            if (in_pfx_reg)
            begin
                pfx_next       = (pfx_sum > 9'd32) ? cidr_pkg::PREFIX_OVER : pfx_sum[5:0];
                pfx_given_next = 1'b1;
            end
            else if (dots_reg < 3'd4)
            begin
                octet_next[sel] = octet_sum;
            end
        end
        else if (ch == cidr_pkg::CH_DOT)
        begin
            nonempty_next = 1'b1;
            if (!in_pfx_reg)
            begin
                if (dots_reg != 3'd7)
                begin
                    dots_next = dots_reg + 3'd1;
                end
                if (idx_reg != 2'd3)
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
        else if (ch == cidr_pkg::CH_SLASH)
        begin
            nonempty_next = 1'b1;
            in_pfx_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octet_reg     <= '0;
            idx_reg       <= 2'd0;
            dots_reg      <= 3'd0;
            in_pfx_reg    <= 1'b0;
            pfx_reg       <= 6'd0;
            pfx_given_reg <= 1'b0;
            nonempty_reg  <= 1'b0;
        end
        else if (fire)
        begin
            octet_reg     <= octet_next;
            idx_reg       <= idx_next;
            dots_reg      <= dots_next;
            in_pfx_reg    <= in_pfx_next;
            pfx_reg       <= pfx_next;
            pfx_given_reg <= pfx_given_next;
            nonempty_reg  <= nonempty_next;
        end
    end

    // Pick the given prefix, or default to one byte per octet seen
    always_comb
    begin
        flag = 1'b0;
        if (pfx_given_reg)
        begin
            len = pfx_reg;
            if (pfx_reg > cidr_pkg::MAX_PREFIX)
            begin
                len  = cidr_pkg::MAX_PREFIX;
                flag = 1'b1;
            end
        end
        else if (dots_reg >= 3'd3)
        begin
            len = cidr_pkg::MAX_PREFIX;
        end
        else
        begin
            len = {1'b0, 2'(dots_reg[1:0] + 2'd1), 3'b000};
        end
    end

    // A shift by 32 clears everything, so the mask becomes all ones
    assign mask = ~(32'hFFFF_FFFF >> len);

    assign emit           = is_newline && nonempty_reg;
    assign res.network    = octet_reg & mask;
    assign res.prefix_len = len;
    assign res.clamped    = flag;

endmodule

// ===== rtl/cidr_out_stage.sv =====
// ----------------------------------------------------------------------------
// cidr_out_stage
// Result register: holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cidr_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cidr_pkg::result_t res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       network,
    output logic [5:0]        prefix_len,
    output logic              clamped
);

    logic              valid_reg;
    logic              valid_next;
    cidr_pkg::result_t res_reg;

    // Slot is free when empty or drained this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = valid_reg;
    assign network    = res_reg.network;
    assign prefix_len = res_reg.prefix_len;
    assign clamped    = res_reg.clamped;

endmodule

// ===== rtl/cidr_checker.sv =====
// ----------------------------------------------------------------------------
// cidr_checker
// Port-level checks of the prefix normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cidr_text_normalizer_macros.svh"

module cidr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] network,
    input logic [5:0]  prefix_len,
    input logic        clamped
);

    // Prefix never exceeds a full address
    `CIDR_ASSERT(a_len_range, !out_valid || prefix_len <= 6'd32)

    // A clamped prefix reports the full length
    `CIDR_ASSERT(a_clamp_len, !out_valid || !clamped || prefix_len == 6'd32)

    // Host bits below the prefix are cleared
    `CIDR_ASSERT(a_host_zero, !out_valid || ((network << prefix_len) == 32'd0) || prefix_len == 6'd32)

    // A stalled result beat holds
    `CIDR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(network) && $stable(prefix_len) && $stable(clamped))

endmodule

bind cidr_text_normalizer cidr_checker u_cidr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .network    (network),
    .prefix_len (prefix_len),
    .clamped    (clamped)
);

// ===== tb/cidr_text_normalizer_tb.sv =====
// ----------------------------------------------------------------------------
// cidr_text_normalizer_tb
// Self-checking bench for the IPv4 prefix text normalizer.
// ----------------------------------------------------------------------------
// Streams prefix text, one character per beat, into the block. The text is a
// few directed lines, then random lines that are mostly well formed, with
// noise and broken lines mixed in. A line tracker follows the same text,
// predicts the masked prefix for every nonempty line and checks each result
// beat in order. Both sides idle at random. The receiver also holds off once
// for a long stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cidr_text_normalizer_tb;

    // Follows the text stream and holds the prefixes still owed by the block
    class cidr_line_tracker;
        logic [31:0]       octets;
        logic [1:0]        octet_sel;
        logic [2:0]        dots;
        bit                after_slash;
        logic [5:0]        prefix_acc;
        bit                prefix_digits;
        bit                line_used;
        cidr_pkg::result_t owed_prefixes[$];
        int                mismatches;
        int                chars_in;
        int                lines_in;
        int                blank_lines;
        int                prefixes_checked;
        int                clamps_seen;

        function new();
            clear_line();
            mismatches       = 0;
            chars_in         = 0;
            lines_in         = 0;
            blank_lines      = 0;
            prefixes_checked = 0;
            clamps_seen      = 0;
        endfunction

        function void clear_line();
            octets        = '0;
            octet_sel     = '0;
            dots          = '0;
            after_slash   = 1'b0;
            prefix_acc    = '0;
            prefix_digits = 1'b0;
            line_used     = 1'b0;
        endfunction

        // Update the line state with one accepted character
        function void take_char(logic [7:0] c);
            int                digit;
            int                shift;
            int                acc;
            int                dflt;
            logic [5:0]        len;
            logic              flag;
            logic [31:0]       mask;
            cidr_pkg::result_t r;
            chars_in++;
            if (c == cidr_pkg::CH_NEWLINE)
            begin
                lines_in++;
                if (line_used)
                begin
                    flag = 1'b0;
                    if (prefix_digits)
                    begin
                        len = prefix_acc;
                        if (prefix_acc > cidr_pkg::MAX_PREFIX)
                        begin
                            len  = cidr_pkg::MAX_PREFIX;
                            flag = 1'b1;
                        end
                    end
                    else
                    begin
                        dflt = (int'(dots) + 1) * 8;
                        len  = (dflt > 32) ? cidr_pkg::MAX_PREFIX : dflt[5:0];
                    end
                    mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - int'(len)));
                    r.network    = octets & mask;
                    r.prefix_len = len;
                    r.clamped    = flag;
                    owed_prefixes.push_back(r);
                end
                else
                begin
                    blank_lines++;
                end
                clear_line();
            end
            else if (c >= cidr_pkg::CH_ZERO && c <= cidr_pkg::CH_NINE)
            begin
                line_used = 1'b1;
                digit     = int'(c - cidr_pkg::CH_ZERO);
                if (after_slash)
                begin
                    acc           = int'(prefix_acc) * 10 + digit;
                    prefix_acc    = (acc > 32) ? cidr_pkg::PREFIX_OVER : acc[5:0];
                    prefix_digits = 1'b1;
                end
                // drop address digits past the fourth octet
                else if (dots < 3'd4)
                begin
                    shift = (3 - int'(octet_sel)) * 8;
                    acc   = (int'(octets[shift +: 8]) * 10 + digit) & 8'hFF;
                    octets[shift +: 8] = acc[7:0];
                end
            end
            else if (c == cidr_pkg::CH_DOT)
            begin
                line_used = 1'b1;
                if (!after_slash)
                begin
                    if (dots != 3'd7)
                        dots++;
                    if (octet_sel != 2'd3)
                        octet_sel++;
                end
            end
            else if (c == cidr_pkg::CH_SLASH)
            begin
                line_used   = 1'b1;
                after_slash = 1'b1;
            end
        endfunction

        // Compare one result beat with the oldest owed prefix
        function void check_prefix(logic [31:0] net, logic [5:0] len, logic clamp);
            cidr_pkg::result_t want;
            if (owed_prefixes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: network=%08h len=%0d clamped=%0b",
                             $realtime, net, len, clamp);
                return;
            end
            want = owed_prefixes.pop_front();
            prefixes_checked++;
            if (clamp)
                clamps_seen++;
            if (net !== want.network || len !== want.prefix_len || clamp !== want.clamped)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch: expected %08h/%0d c=%0b, got %08h/%0d c=%0b",
                             $realtime, want.network, want.prefix_len, want.clamped,
                             net, len, clamp);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] network;
    logic [5:0]  prefix_len;
    logic        clamped;

    cidr_line_tracker tracker;
    bit               tx_idle;
    bit               rx_idle;
    int               hold_request;

    cidr_text_normalizer dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .network    (network),
        .prefix_len (prefix_len),
        .clamped    (clamped)
    );

    // Generate the 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Offer one character and hold it until the beat is taken
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_char(c);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Build and send one random line: mostly well formed, some noise
    task automatic send_random_line();
        string s;
        string alphabet;
        int    kind;
        int    n_oct;
        int    sel;
        int    i;
        s        = "";
        alphabet = "0123456789./";
        kind     = $urandom_range(0, 9);
        if (kind < 8)
        begin
            n_oct = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            for (i = 0; i < n_oct; i++)
            begin
                if (i > 0)
                    s = {s, "."};
                sel = $urandom_range(0, 11);
                if (sel == 1)
                    s = {s, $sformatf("%0d", $urandom_range(256, 999))};
                else if (sel != 0)
                    s = {s, $sformatf("%0d", $urandom_range(0, 255))};
            end
            if ($urandom_range(0, 2) != 0)
            begin
                s   = {s, "/"};
                sel = $urandom_range(0, 9);
                if (sel == 1)
                    s = {s, $sformatf("%0d", $urandom_range(33, 999))};
                else if (sel != 0)
                    s = {s, $sformatf("%0d", $urandom_range(0, 32))};
            end
            send_text(s);
            if ($urandom_range(0, 7) == 0)
                send_char(8'($urandom_range(0, 255)));
        end
        else if (kind == 8)
        begin
            repeat ($urandom_range(0, 8))
                send_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 10))
                send_char(alphabet[$urandom_range(0, 11)]);
        end
        send_char(cidr_pkg::CH_NEWLINE);
    endtask

    // Take result beats, idling at random and once holding off for long
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = rx_idle ? $urandom_range(0, 4) : 0;
            if (hold_request > 0)
            begin
                gap          = hold_request;
                hold_request = 0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            tracker.check_prefix(network, prefix_len, clamped);
            if ($urandom_range(0, 19) == 0)
                rx_idle = !rx_idle;
        end
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Reset, directed lines, random lines, then drain
    initial
    begin
        int  waited;
        int  leftover;
        bit  hold_done;
        tracker      = new();
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_request = 0;
        hold_done    = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        ch       <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // blank line, then a line of ignored bytes only
        send_char(cidr_pkg::CH_NEWLINE);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(cidr_pkg::CH_NEWLINE);
        // octet past 255, given prefix above 32
        send_text("300.1/99\n");
        // more than four octets, dot count saturates, slash with no digits
        send_text("1.2.3.4.5.6.7.8/\n");
        // prefix zero, dot and second slash after the slash
        send_text("9/0./\n");
        // empty octet in the middle
        send_text("1..3\n");

        // random lines, with no-idle stretches and one long receiver hold
        while (tracker.chars_in < 1230)
        begin
            if ($urandom_range(0, 5) == 0)
                tx_idle = !tx_idle;
            if (!hold_done && tracker.chars_in > 600)
            begin
                hold_request = 300;
                hold_done    = 1'b1;
            end
            send_random_line();
        end
        in_valid <= 1'b0;

        // wait for the block to drain
        waited = 0;
        while (tracker.owed_prefixes.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        leftover = tracker.owed_prefixes.size();
        if (leftover != 0)
            $display("%0d expected prefixes never arrived", leftover);
        $display("Sent %0d characters in %0d lines (%0d blank); checked %0d prefixes, %0d clamped",
                 tracker.chars_in, tracker.lines_in, tracker.blank_lines,
                 tracker.prefixes_checked, tracker.clamps_seen);
        $display("Mismatches: %0d", tracker.mismatches);
        if (tracker.mismatches == 0 && leftover == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
